FILE: src/gamepad_key_event_queue_defines.svh
// Assertion macros for the gamepad key event queue.
// Included by the top level; no other dependencies.
`ifndef GAMEPAD_KEY_EVENT_QUEUE_DEFINES_SVH
`define GAMEPAD_KEY_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define GKEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gkeq same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define GKEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gkeq next-cycle check failed");
`else
`define GKEQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GKEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/gkeq_pkg.sv
// Shared types, constants and the key code table of the key event queue.
// No dependencies; imported by gkeq_ctrl, gkeq_dp and the top level.
package gkeq_pkg;

  localparam int NUM_KEYS  = 12;
  localparam int KEY_IDX_W = 4;
  localparam int CODE_W    = 8;
  localparam int EVT_W     = CODE_W + 1;
  localparam int THR_W     = 8;

  localparam logic [THR_W-1:0] JOY_HIGH_RST = 8'hB0;
  localparam logic [THR_W-1:0] JOY_LOW_RST  = 8'h60;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic CFG_JOY_HIGH = 1'b0;
  localparam logic CFG_JOY_LOW  = 1'b1;

  typedef struct packed {
    logic load_sample;
    logic scan_step;
    logic pop;
    logic out_load_empty;
    logic out_load_data;
  } gkeq_cmd_t;

  typedef struct packed {
    logic last_key;
    logic empty;
    logic out_free;
  } gkeq_status_t;

  function automatic logic [CODE_W-1:0] key_code(input logic [KEY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    unique case (idx)
      4'd0:    code = 8'h1B;
      4'd1:    code = 8'h0D;
      4'd2:    code = 8'hA3;
      4'd3:    code = 8'hA2;
      4'd4:    code = 8'hA0;
      4'd5:    code = 8'hB6;
      4'd6:    code = 8'h2C;
      4'd7:    code = 8'h2E;
      4'd8:    code = 8'hAC;
      4'd9:    code = 8'hAE;
      4'd10:   code = 8'hAD;
      4'd11:   code = 8'hAF;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: src/gkeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gkeq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/gkeq_ctrl.sv
// Controller of the key event queue: accepts requests and sequences the datapath.
// Depends on gkeq_pkg.
module gkeq_ctrl
  import gkeq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_op,
  output logic         in_ready,
  input  gkeq_status_t st,
  output gkeq_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_RD_DATA
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SAMPLE) begin
            cmd.load_sample = 1'b1;
            state_nxt       = S_SCAN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.last_key) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        // hold until the result register can take the answer
        if (st.out_free) begin
          if (st.empty) begin
            cmd.out_load_empty = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = S_RD_DATA;
          end
        end
      end
      S_RD_DATA: begin
        cmd.out_load_data = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/gkeq_dp.sv
// Datapath of the key event queue: thresholds, key compare, ring and result register.
// Depends on gkeq_pkg and gkeq_ram.
module gkeq_dp
  import gkeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [THR_W-1:0]  cfg_wdata,
  input  logic [7:0]        buttons,
  input  logic [7:0]        joy_x,
  input  logic [7:0]        joy_y,
  input  gkeq_cmd_t         cmd,
  output gkeq_status_t      st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_event_valid,
  output logic              out_key_pressed,
  output logic [CODE_W-1:0] out_key_code
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [THR_W-1:0]     joy_high_r, joy_low_r;
  logic [NUM_KEYS-1:0]  prev_r, now_r, now_in;
  logic [KEY_IDX_W-1:0] key_idx_r;
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r, wr_next, rd_next;
  logic                 full, cur_bit, changed, ring_we;
  logic [EVT_W-1:0]     ring_wdata, ring_rdata;
  logic                 out_valid_r, out_evt_r, out_pressed_r;
  logic [CODE_W-1:0]    out_code_r;

  assign now_in = {joy_y <= joy_low_r, joy_y >= joy_high_r,
                   joy_x <= joy_low_r, joy_x >= joy_high_r, buttons};

  assign wr_next = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_next = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign full    = (wr_next == rd_ptr_r);

  assign cur_bit    = now_r[key_idx_r];
  assign changed    = cur_bit != prev_r[key_idx_r];
  assign ring_we    = cmd.scan_step && changed && !full;
  assign ring_wdata = {cur_bit, key_code(key_idx_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joy_high_r <= JOY_HIGH_RST;
      joy_low_r  <= JOY_LOW_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_JOY_HIGH) begin
        joy_high_r <= cfg_wdata;
      end else begin
        joy_low_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      key_idx_r <= '0;
    end else begin
      if (cmd.load_sample) begin
        key_idx_r <= '0;
      end else if (cmd.scan_step) begin
        key_idx_r <= key_idx_r + 1'b1;
      end
      // previous value follows the input even when the event is dropped
      if (cmd.scan_step && changed) begin
        prev_r[key_idx_r] <= cur_bit;
      end
      if (ring_we) begin
        wr_ptr_r <= wr_next;
      end
      if (cmd.pop) begin
        rd_ptr_r <= rd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      now_r <= now_in;
    end
  end

  gkeq_ram #(
    .WIDTH(EVT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_ptr_r),
    .wdata (ring_wdata),
    .re    (cmd.pop),
    .raddr (rd_ptr_r),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load_empty || cmd.out_load_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_empty) begin
      out_evt_r     <= 1'b0;
      out_pressed_r <= 1'b0;
      out_code_r    <= '0;
    end else if (cmd.out_load_data) begin
      out_evt_r     <= 1'b1;
      out_pressed_r <= ring_rdata[EVT_W-1];
      out_code_r    <= ring_rdata[CODE_W-1:0];
    end
  end

  assign st.last_key = (key_idx_r == KEY_IDX_W'(NUM_KEYS - 1));
  assign st.empty    = (rd_ptr_r == wr_ptr_r);
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_event_valid = out_evt_r;
  assign out_key_pressed = out_pressed_r;
  assign out_key_code    = out_code_r;

endmodule

FILE: src/gamepad_key_event_queue.sv
// Gamepad key event queue, top level: controller, datapath and checks.
// Depends on gkeq_pkg, gkeq_ctrl, gkeq_dp and the defines header.
//
//  channel | direction | tdata                                | tuser
//  in_     | slave     | buttons[7:0] joy_x[15:8] joy_y[23:16] | op
//  out_    | master    | key_pressed[0] key_code[8:1]         | event_valid
//  cfg_    | write     | cfg_index selects, cfg_wdata[7:0]    | -
//
// A sample request is accepted, then the twelve keys are compared one at a time
// against the stored state; a changed key is written to the ring unless full.
// A read of an empty queue ends in S_RD; else S_RD starts the registered ring
// read and S_RD_DATA loads it. A read waits while the result register is full.
// Reset (rst_n, synchronous) empties the queue and clears the key state.
`include "gamepad_key_event_queue_defines.svh"

module gamepad_key_event_queue
  import gkeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // buttons[7:0], joy_x[15:8], joy_y[23:16]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // key_pressed[0], key_code[8:1], zero pad
  output logic        out_tuser,  // event_valid
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  gkeq_cmd_t    cmd;
  gkeq_status_t st;
  logic         key_pressed;
  logic [7:0]   key_code;

  gkeq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gkeq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .buttons         (in_tdata[7:0]),
    .joy_x           (in_tdata[15:8]),
    .joy_y           (in_tdata[23:16]),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_event_valid (out_tuser),
    .out_key_pressed (key_pressed),
    .out_key_code    (key_code)
  );

  assign out_tdata = {7'd0, key_code, key_pressed};

  `GKEQ_ASSERT_SAME(a_pop_not_empty, clk, rst_n, cmd.pop, !st.empty)
  `GKEQ_ASSERT_SAME(a_load_into_free, clk, rst_n,
                    cmd.out_load_empty || cmd.out_load_data, st.out_free)
  `GKEQ_ASSERT_NEXT(a_pop_then_load, clk, rst_n, cmd.pop, cmd.out_load_data)
  `GKEQ_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_tvalid),
                    $past(cmd.out_load_empty) || $past(cmd.out_load_data))

endmodule
